FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the shader block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define PLD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("shader port check failed");

// Clocked assertion that also holds across reset.
`define PLD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("shader reset check failed");

`endif

FILE: hw/rtl/pld_pkg.sv
// Package of the point light diffuse shader: fixed widths, register indexes,
// reset values, stage types and the final channel scaling function. No dependencies.
package pld_pkg;

    localparam int LEVEL_W   = 9;
    localparam int CH_W      = 8;
    localparam int MAG_W     = 17;
    localparam int SUM_W     = 34;
    localparam int ROOT_W    = 17;
    localparam int QUO_W     = 18;
    localparam int DIV_W     = 51;
    localparam int DSH_W     = DIV_W + QUO_W;
    localparam int F_W       = 17;
    localparam int TOTAL_W   = 18;
    localparam int PROD_W    = 27;
    localparam int NUM_SHIFT = 25;
    localparam int REG_IDX_W = 3;

    localparam logic [F_W-1:0] F_SAT = 17'h10000;

    localparam logic [REG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AMBIENT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAT_RED   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAT_GREEN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAT_BLUE  = 3'd7;

    localparam int                 LIGHT_Z_RST   = 4096;
    localparam logic [LEVEL_W-1:0] AMBIENT_RST   = 9'd26;
    localparam logic [LEVEL_W-1:0] GAIN_RST      = 9'd205;
    localparam logic [LEVEL_W-1:0] MAT_RED_RST   = 9'd256;
    localparam logic [LEVEL_W-1:0] MAT_GREEN_RST = 9'd0;
    localparam logic [LEVEL_W-1:0] MAT_BLUE_RST  = 9'd0;

    typedef struct packed {
        logic [SUM_W-1:0]  s;
        logic [ROOT_W-1:0] r;
        logic [SUM_W-1:0]  sq;
        logic [MAG_W-1:0]  az;
        logic              zf;
        logic              off;
    } sqrt_stage_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [QUO_W-1:0] q;
        logic             zf;
        logic             off;
    } div_stage_t;

    // Clamp the Q.16 product to one and scale by 255, truncating.
    function automatic logic [CH_W-1:0] shade_channel(input logic [PROD_W-1:0] p);
        logic [23:0] scaled;
        begin
            scaled = {p[15:0], 8'b0} - {8'b0, p[15:0]};
            return (|p[PROD_W-1:16]) ? 8'hFF : scaled[23:16];
        end
    endfunction

endpackage

FILE: hw/rtl/point_light_diffuse_shader.sv
// Point light diffuse shader: takes one fragment world position per cycle while the
// output is not stalled and returns its RGB color, ambient plus gain * 2/|d|^2 *
// max(0, -d_z/|d|), times the material, clamped and scaled to 0..255. It sustains one
// item per clock unless stalled; the 17-stage square root and the 18-stage divider
// decide one result bit per stage. Every stage holds its item under back-pressure; no
// item is lost. Write configuration only while no item is in flight. Uses pld_pkg.
module point_light_diffuse_shader import pld_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [((COORD_WIDTH > LEVEL_W) ? COORD_WIDTH : LEVEL_W)-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_world_x,
    input  logic signed [COORD_WIDTH-1:0] s_world_y,
    input  logic signed [COORD_WIDTH-1:0] s_world_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CH_W-1:0]               m_red,
    output logic [CH_W-1:0]               m_green,
    output logic [CH_W-1:0]               m_blue
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;                       // difference width
    localparam int MW = (DW > MAG_W + 1) ? DW : MAG_W + 1;
    localparam int SQRT_N = ROOT_W;
    localparam int DIV_N  = QUO_W;
    localparam int ST_SUM  = 3;
    localparam int ST_DIV0 = ST_SUM + SQRT_N + 1;
    localparam int ST_F    = ST_DIV0 + DIV_N + 1;
    localparam int ST_PROD = ST_F + 1;
    localparam int NS      = ST_PROD + 2;

    // Configuration registers
    logic signed [CW-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [LEVEL_W-1:0]   ambient_reg, gain_reg;
    logic [LEVEL_W-1:0]   mat_red_reg, mat_green_reg, mat_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg   <= '0;
            light_y_reg   <= '0;
            light_z_reg   <= CW'(LIGHT_Z_RST);
            ambient_reg   <= AMBIENT_RST;
            gain_reg      <= GAIN_RST;
            mat_red_reg   <= MAT_RED_RST;
            mat_green_reg <= MAT_GREEN_RST;
            mat_blue_reg  <= MAT_BLUE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LIGHT_X:   light_x_reg   <= cfg_wdata[CW-1:0];
                REG_LIGHT_Y:   light_y_reg   <= cfg_wdata[CW-1:0];
                REG_LIGHT_Z:   light_z_reg   <= cfg_wdata[CW-1:0];
                REG_AMBIENT:   ambient_reg   <= cfg_wdata[LEVEL_W-1:0];
                REG_GAIN:      gain_reg      <= cfg_wdata[LEVEL_W-1:0];
                REG_MAT_RED:   mat_red_reg   <= cfg_wdata[LEVEL_W-1:0];
                REG_MAT_GREEN: mat_green_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_MAT_BLUE:  mat_blue_reg  <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage advances when it is empty or the next one advances.
    logic [NS:0]   rdy;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_in;

    assign rdy[NS]  = m_ready;
    assign vld_in   = {vld_reg[NS-2:0], s_valid};
    assign s_ready  = rdy[0];
    assign m_valid  = vld_reg[NS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_rdy
            assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Stage 0: differences to the light
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;

    // Stage 1: magnitudes and special-case flags
    logic [DW-1:0]    mag_x, mag_y, mag_z;
    logic [MW-1:0]    ext_x, ext_y, ext_z;
    logic             big_any;
    logic [MAG_W-1:0] ax_reg, ay_reg, az1_reg;
    logic             zf1_reg, off1_reg;

    always_comb begin
        mag_x = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        mag_y = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        mag_z = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);
        ext_x = MW'(mag_x);
        ext_y = MW'(mag_y);
        ext_z = MW'(mag_z);
        // A component at or beyond 2^17 makes the diffuse quotient vanish.
        big_any = (|ext_x[MW-1:MAG_W]) || (|ext_y[MW-1:MAG_W]) || (|ext_z[MW-1:MAG_W]);
    end

    // Stage 2: squares
    logic [SUM_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [MAG_W-1:0] az2_reg;
    logic             zf2_reg, off2_reg;

    // Square root stages: entry 0 holds the sum, entry j has root bit 17-j decided.
    sqrt_stage_t     sr_reg  [0:SQRT_N];
    sqrt_stage_t     sr_next [0:SQRT_N];
    logic [SUM_W+1:0] ssum;

    always_comb begin
        logic [SUM_W:0] t2;
        ssum = (SUM_W+2)'(sqx_reg) + (SUM_W+2)'(sqy_reg) + (SUM_W+2)'(sqz_reg);
        sr_next[0].s   = ssum[SUM_W-1:0];
        sr_next[0].r   = '0;
        sr_next[0].sq  = '0;
        sr_next[0].az  = az2_reg;
        sr_next[0].zf  = zf2_reg;
        sr_next[0].off = off2_reg || (|ssum[SUM_W+1:SUM_W]);
        for (int j = 1; j <= SQRT_N; j++) begin
            sr_next[j] = sr_reg[j-1];
            // (r + b)^2 = r^2 + 2rb + b^2 with b = 2^k
            t2 = {1'b0, sr_reg[j-1].sq}
               + ((SUM_W+1)'(sr_reg[j-1].r) << (SQRT_N - j + 1))
               + ((SUM_W+1)'(1) << (2 * (SQRT_N - j)));
            if (t2 <= {1'b0, sr_reg[j-1].s}) begin
                sr_next[j].r  = sr_reg[j-1].r | (ROOT_W'(1) << (SQRT_N - j));
                sr_next[j].sq = t2[SUM_W-1:0];
            end
        end
    end

    // Divider stages: entry 0 holds numerator and S*R, entry j has quotient bit 18-j.
    div_stage_t   dv_reg  [0:DIV_N];
    div_stage_t   dv_next [0:DIV_N];
    logic [LEVEL_W+MAG_W-1:0] gain_az;

    always_comb begin
        logic [DSH_W-1:0] dsh;
        gain_az        = (LEVEL_W+MAG_W)'(gain_reg) * (LEVEL_W+MAG_W)'(sr_reg[SQRT_N].az);
        dv_next[0].rem = DIV_W'(gain_az) << NUM_SHIFT;
        dv_next[0].den = DIV_W'(sr_reg[SQRT_N].s) * DIV_W'(sr_reg[SQRT_N].r);
        dv_next[0].q   = '0;
        dv_next[0].zf  = sr_reg[SQRT_N].zf;
        dv_next[0].off = sr_reg[SQRT_N].off;
        for (int j = 1; j <= DIV_N; j++) begin
            dv_next[j] = dv_reg[j-1];
            dsh = DSH_W'(dv_reg[j-1].den) << (DIV_N - j);
            if (DSH_W'(dv_reg[j-1].rem) >= dsh) begin
                dv_next[j].rem = dv_reg[j-1].rem - dsh[DIV_W-1:0];
                dv_next[j].q   = dv_reg[j-1].q | (QUO_W'(1) << (DIV_N - j));
            end
        end
    end

    // Diffuse term: zero distance saturates, light behind or far gives zero.
    logic [F_W-1:0]     f_val;
    logic [TOTAL_W-1:0] total_reg;
    logic [PROD_W-1:0]  pr_reg, pg_reg, pb_reg;
    logic [CH_W-1:0]    red_reg, green_reg, blue_reg;

    always_comb begin
        if (dv_reg[DIV_N].zf) begin
            f_val = F_SAT;
        end else if (dv_reg[DIV_N].off) begin
            f_val = '0;
        end else if (dv_reg[DIV_N].q > QUO_W'(F_SAT)) begin
            f_val = F_SAT;
        end else begin
            f_val = dv_reg[DIV_N].q[F_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            dx_reg <= {s_world_x[CW-1], s_world_x} - {light_x_reg[CW-1], light_x_reg};
            dy_reg <= {s_world_y[CW-1], s_world_y} - {light_y_reg[CW-1], light_y_reg};
            dz_reg <= {s_world_z[CW-1], s_world_z} - {light_z_reg[CW-1], light_z_reg};
        end
        if (rdy[1]) begin
            ax_reg   <= ext_x[MAG_W-1:0];
            ay_reg   <= ext_y[MAG_W-1:0];
            az1_reg  <= ext_z[MAG_W-1:0];
            zf1_reg  <= (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
            off1_reg <= !dz_reg[DW-1] || big_any;
        end
        if (rdy[2]) begin
            sqx_reg  <= SUM_W'(ax_reg) * SUM_W'(ax_reg);
            sqy_reg  <= SUM_W'(ay_reg) * SUM_W'(ay_reg);
            sqz_reg  <= SUM_W'(az1_reg) * SUM_W'(az1_reg);
            az2_reg  <= az1_reg;
            zf2_reg  <= zf1_reg;
            off2_reg <= off1_reg;
        end
        for (int j = 0; j <= SQRT_N; j++) begin
            if (rdy[ST_SUM + j]) begin
                sr_reg[j] <= sr_next[j];
            end
        end
        for (int j = 0; j <= DIV_N; j++) begin
            if (rdy[ST_DIV0 + j]) begin
                dv_reg[j] <= dv_next[j];
            end
        end
        if (rdy[ST_F]) begin
            total_reg <= TOTAL_W'(ambient_reg) + TOTAL_W'(f_val);
        end
        if (rdy[ST_PROD]) begin
            pr_reg <= PROD_W'(mat_red_reg) * PROD_W'(total_reg);
            pg_reg <= PROD_W'(mat_green_reg) * PROD_W'(total_reg);
            pb_reg <= PROD_W'(mat_blue_reg) * PROD_W'(total_reg);
        end
        if (rdy[NS-1]) begin
            red_reg   <= shade_channel(pr_reg);
            green_reg <= shade_channel(pg_reg);
            blue_reg  <= shade_channel(pb_reg);
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

FILE: hw/rtl/pld_checker.sv
// Port-level checker for the point light diffuse shader, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pld_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue
);

    `PLD_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable({m_red, m_green, m_blue}))
    `PLD_ASSERT(a_stall_from_out, aclk, aresetn, !s_ready |-> m_valid && !m_ready)
    `PLD_ASSERT_NORST(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready)

endmodule

bind point_light_diffuse_shader pld_checker u_pld_checker (.*);
